>>> rtl/assert_macros.svh
// Assertion helpers included by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/rrqs_pkg.sv
package rrqs_pkg;

   localparam int DEF_SLOTS        = 16;
   localparam int DEF_QUANTUM_BITS = 16;

   // Slot state codes.
   localparam logic [2:0] SLOT_EMPTY    = 3'd0;
   localparam logic [2:0] SLOT_RUNNABLE = 3'd1;
   localparam logic [2:0] SLOT_RUNNING  = 3'd2;
   localparam logic [2:0] SLOT_BLOCKED  = 3'd3;
   localparam logic [2:0] SLOT_KILLED   = 3'd4;
   localparam logic [2:0] SLOT_REPLACED = 3'd5;

   // Request actions.
   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_LOAD = 2'd1;
   localparam logic [1:0] ACT_SET  = 2'd2;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_WRITE,
      FSM_CHECK,
      FSM_SCAN,
      FSM_FINISH
   } fsm_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  slot;
      logic [2:0]  new_state;
      logic [15:0] quantum;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic       do_switch;
      logic       save_old;
      logic [3:0] new_index;
      logic [3:0] preempt_index;
   } rsp_type;

endpackage

>>> rtl/rrqs_ram.sv
module rrqs_ram
   import rrqs_pkg::*;
#(
   parameter int WIDTH = 3,
   parameter int DEPTH = DEF_SLOTS
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_ff <= mem_ff[raddr];
   end

   assign rdata = rd_ff;

endmodule

>>> rtl/round_robin_quantum_scheduler.sv
// Round-robin time-slice scheduler over a table of task slots.
//
// Requests arrive as one beat on req_data, taken at a clock edge where start
// is high and busy is low. A beat loads a slot (state and quantum, used ticks
// cleared), sets a slot's state, or delivers a timer tick. Every request beat
// produces exactly one response beat on rsp_data, marked by rsp_strobe for a
// single cycle; the receiver cannot stall, so it must take the beat then.
//
// A load or set-state beat reads the old state of its slot, then writes the
// new one and answers. A tick that has nothing live answers straight from
// idle; a tick that only counts reads the current slot first. A tick that
// must pick a new slot scans the whole state memory, one entry per cycle
// through its single read port; on a first start the scan begins at once,
// otherwise the current slot is read first. One request is in flight at a
// time; busy stays high until the response is produced.
//
// After reset the block sweeps both memories, one entry per cycle, to put
// every slot in the empty state with zero used ticks; busy is high for the
// whole sweep.
module round_robin_quantum_scheduler
   import rrqs_pkg::*;
#(
   parameter int SLOTS        = DEF_SLOTS,
   parameter int QUANTUM_BITS = DEF_QUANTUM_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

`include "assert_macros.svh"

   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int QB = QUANTUM_BITS;
   localparam logic [QB-1:0] QMAX = '1;
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

   // State memory holds the slot state; the count memory holds
   // {quantum, used ticks} for each slot.
   logic          st_we;
   logic [SW-1:0] st_wa;
   logic [2:0]    st_wd;
   logic [SW-1:0] st_ra;
   logic [2:0]    st_rd;

   logic            ct_we;
   logic [SW-1:0]   ct_wa;
   logic [2*QB-1:0] ct_wd;
   logic [SW-1:0]   ct_ra;
   logic [2*QB-1:0] ct_rd;
   logic [QB-1:0]   ct_qnt;
   logic [QB-1:0]   ct_used;
   logic [QB-1:0]   used_inc;

   rrqs_ram #(.WIDTH(3), .DEPTH(SLOTS)) u_state_ram (
      .clock (clock),
      .we    (st_we),
      .waddr (st_wa),
      .wdata (st_wd),
      .raddr (st_ra),
      .rdata (st_rd)
   );

   rrqs_ram #(.WIDTH(2 * QB), .DEPTH(SLOTS)) u_count_ram (
      .clock (clock),
      .we    (ct_we),
      .waddr (ct_wa),
      .wdata (ct_wd),
      .raddr (ct_ra),
      .rdata (ct_rd)
   );

   assign ct_qnt   = ct_rd[2*QB-1:QB];
   assign ct_used  = ct_rd[QB-1:0];
   assign used_inc = (ct_used == QMAX) ? ct_used : ct_used + QB'(1);

   fsm_type       fsm_ff, fsm_in;
   req_type       req_ff, req_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] cur_ff, cur_in;
   logic          started_ff, started_in;
   logic [CW-1:0] live_ff, live_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pend_ff, pend_in;
   logic [SW-1:0] pend_idx_ff, pend_idx_in;
   logic          found_ff, found_in;
   logic [SW-1:0] found_idx_ff, found_idx_in;
   logic          clr_ff, clr_in;
   logic          exp_ff, exp_in;

   // Slot field and quantum as the table sees them.
   logic [31:0]   in_slot_wide;
   logic          in_slot_ok;
   logic [31:0]   req_slot_wide;
   logic [31:0]   req_q_wide;
   logic [31:0]   cur_wide;
   logic [31:0]   found_wide;

   assign in_slot_wide  = {28'd0, req_data.slot};
   assign in_slot_ok    = in_slot_wide < 32'(SLOTS);
   assign req_slot_wide = {28'd0, req_ff.slot};
   assign req_q_wide    = {16'd0, req_ff.quantum};
   assign cur_wide      = {{(32 - SW){1'b0}}, cur_ff};
   assign found_wide    = {{(32 - SW){1'b0}}, found_idx_ff};

   function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] v);
      wrap_inc = (v == LAST_SLOT) ? '0 : v + SW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= FSM_CLEAR;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
         started_ff   <= 1'b0;
         live_ff      <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         started_ff   <= started_in;
         live_ff      <= live_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
      end
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      pend_idx_ff  <= pend_idx_in;
      found_idx_ff <= found_idx_in;
      clr_ff       <= clr_in;
      exp_ff       <= exp_in;
   end

   always_comb begin
      fsm_in       = fsm_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      cur_in       = cur_ff;
      started_in   = started_ff;
      live_in      = live_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      clr_in       = clr_ff;
      exp_in       = exp_ff;

      st_we = 1'b0;
      st_wa = idx_ff;
      st_wd = SLOT_EMPTY;
      st_ra = idx_ff;
      ct_we = 1'b0;
      ct_wa = idx_ff;
      ct_wd = '0;
      ct_ra = idx_ff;

      case (fsm_ff)
         FSM_CLEAR: begin
            st_we  = 1'b1;
            ct_we  = 1'b1;
            idx_in = wrap_inc(idx_ff);
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(SLOTS - 1)) begin
               idx_in = '0;
               fsm_in = FSM_IDLE;
            end
         end

         FSM_IDLE: begin
            if (start) begin
               req_in = req_data;
               rsp_in = '0;
               case (req_data.action)
                  ACT_LOAD, ACT_SET: begin
                     if (in_slot_ok &&
                         (req_data.new_state inside {[SLOT_EMPTY:SLOT_REPLACED]})) begin
                        st_ra  = in_slot_wide[SW-1:0];
                        fsm_in = FSM_WRITE;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  ACT_TICK: begin
                     if (live_ff == '0) begin
                        rsp_in.save_old = 1'b1;
                        rsp_valid_in    = 1'b1;
                     end else if (!started_ff) begin
                        // First start searches from the slot after slot 0.
                        idx_in   = wrap_inc('0);
                        cnt_in   = '0;
                        pend_in  = 1'b0;
                        found_in = 1'b0;
                        clr_in   = 1'b0;
                        exp_in   = 1'b0;
                        fsm_in   = FSM_SCAN;
                     end else begin
                        st_ra  = cur_ff;
                        ct_ra  = cur_ff;
                        fsm_in = FSM_CHECK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         FSM_WRITE: begin
            st_we = 1'b1;
            st_wa = req_slot_wide[SW-1:0];
            st_wd = req_ff.new_state;
            if (req_ff.action == ACT_LOAD) begin
               ct_we = 1'b1;
               ct_wa = req_slot_wide[SW-1:0];
               ct_wd = {req_q_wide[QB-1:0], {QB{1'b0}}};
            end
            if (st_rd == SLOT_EMPTY && req_ff.new_state != SLOT_EMPTY) begin
               live_in = live_ff + CW'(1);
            end else if (st_rd != SLOT_EMPTY && req_ff.new_state == SLOT_EMPTY) begin
               live_in = live_ff - CW'(1);
            end
            rsp_in       = '0;
            rsp_valid_in = 1'b1;
            fsm_in       = FSM_IDLE;
         end

         FSM_CHECK: begin
            rsp_in = '0;
            if (st_rd != SLOT_RUNNING) begin
               // The current task stopped: sweep out dead slots and pick anew.
               idx_in   = wrap_inc(cur_ff);
               cnt_in   = '0;
               pend_in  = 1'b0;
               found_in = 1'b0;
               clr_in   = 1'b1;
               exp_in   = 1'b0;
               fsm_in   = FSM_SCAN;
            end else if (live_ff == CW'(1)) begin
               rsp_in.ok       = 1'b1;
               rsp_in.save_old = 1'b1;
               rsp_valid_in    = 1'b1;
               fsm_in          = FSM_IDLE;
            end else if (used_inc >= ct_qnt) begin
               // Quantum used up: the slot goes back in line, and the search
               // may come round to it again.
               st_we    = 1'b1;
               st_wa    = cur_ff;
               st_wd    = SLOT_RUNNABLE;
               ct_we    = 1'b1;
               ct_wa    = cur_ff;
               ct_wd    = {ct_qnt, {QB{1'b0}}};
               idx_in   = wrap_inc(cur_ff);
               cnt_in   = '0;
               pend_in  = 1'b0;
               found_in = 1'b0;
               clr_in   = 1'b0;
               exp_in   = 1'b1;
               fsm_in   = FSM_SCAN;
            end else begin
               ct_we           = 1'b1;
               ct_wa           = cur_ff;
               ct_wd           = {ct_qnt, used_inc};
               rsp_in.ok       = 1'b1;
               rsp_in.save_old = 1'b1;
               rsp_valid_in    = 1'b1;
               fsm_in          = FSM_IDLE;
            end
         end

         FSM_SCAN: begin
            // Issue one read per cycle; the data of the read issued in the
            // previous cycle is examined in this one.
            if (cnt_ff != CW'(SLOTS)) begin
               st_ra       = idx_ff;
               ct_ra       = idx_ff;
               idx_in      = wrap_inc(idx_ff);
               cnt_in      = cnt_ff + CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
            end else begin
               pend_in = 1'b0;
               fsm_in  = FSM_FINISH;
            end
            if (pend_ff) begin
               if (clr_ff && (st_rd inside {SLOT_KILLED, SLOT_REPLACED})) begin
                  st_we   = 1'b1;
                  st_wa   = pend_idx_ff;
                  st_wd   = SLOT_EMPTY;
                  ct_we   = 1'b1;
                  ct_wa   = pend_idx_ff;
                  ct_wd   = {ct_qnt, {QB{1'b0}}};
                  live_in = live_ff - CW'(1);
               end
               if (st_rd == SLOT_RUNNABLE && !found_ff) begin
                  found_in     = 1'b1;
                  found_idx_in = pend_idx_ff;
               end
            end
         end

         FSM_FINISH: begin
            rsp_in = '0;
            if (exp_ff) begin
               rsp_in.preempt_index = cur_wide[3:0];
            end
            if (found_ff) begin
               st_we            = 1'b1;
               st_wa            = found_idx_ff;
               st_wd            = SLOT_RUNNING;
               cur_in           = found_idx_ff;
               started_in       = 1'b1;
               rsp_in.ok        = 1'b1;
               rsp_in.do_switch = 1'b1;
               rsp_in.save_old  = exp_ff;
               rsp_in.new_index = found_wide[3:0];
            end else begin
               rsp_in.save_old = 1'b1;
            end
            rsp_valid_in = 1'b1;
            fsm_in       = FSM_IDLE;
         end

         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase
   end

   assign busy       = (fsm_ff != FSM_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // The live count never exceeds the table size.
   `ASSERT_SAME(a_live_bound, clock, reset, 1'b1, live_ff <= CW'(SLOTS), "live count overflow")
   // Once a task has been started the scheduler never forgets it.
   `ASSERT_NEXT(a_started_sticky, clock, reset, started_ff, started_ff, "started flag dropped")
   // The last scan step always yields a response beat.
   `ASSERT_NEXT(a_finish_rsp, clock, reset, fsm_ff == FSM_FINISH, rsp_strobe,
                "no response after scan")
   // A tick taken with nothing live answers at once with failure.
   `ASSERT_NEXT(a_empty_tick, clock, reset,
                start && !busy && req_data.action == ACT_TICK && live_ff == '0,
                rsp_strobe && !rsp_data.ok && rsp_data.save_old,
                "empty tick not failed")
   // A reported switch always comes with a running task.
   `ASSERT_SAME(a_switch_ok, clock, reset, rsp_strobe && rsp_data.do_switch,
                rsp_data.ok && started_ff, "switch without running task")

endmodule
